[src/serial_command_decoder_fan_control_unit_defines.svh]
// assertion macros shared by the decoder rtl
// no dependencies; each macro expects clk and arst_n in scope
`ifndef SERIAL_COMMAND_DECODER_FAN_CONTROL_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_DECODER_FAN_CONTROL_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SCDFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SCDFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/scdfc_pkg.sv]
// types, codes and tables for the serial command decoder
// no dependencies
`default_nettype none
package scdfc_pkg;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic       duty_load;
		logic [9:0] duty_value;
		logic [2:0] speed_level;
		logic       coil_valid;
		logic [3:0] coil_pattern;
		logic       relay_level;
		logic       sensor_request;
		logic       auto_mode;
		logic [2:0] setup_stage;
		logic       last;
	} out_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_ACK  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_S    = 3'd1,
		CMD_D    = 3'd2,
		CMD_X    = 3'd3,
		CMD_Y    = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic decode;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic final_beat;
	} dp_sts_t;

	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_6 = 8'h36;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_8 = 8'h38;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic [2:0] STAGE_PREFIX = 3'd3;
	localparam logic [2:0] STAGE_RUN    = 3'd4;

	localparam logic [9:0] DUTY_FULL = 10'd1023;
	localparam logic [9:0] DUTY_HIGH = 10'd500;
	localparam logic [9:0] DUTY_MID  = 10'd330;
	localparam logic [9:0] DUTY_LOW  = 10'd170;
	localparam logic [9:0] DUTY_OFF  = 10'd0;

	localparam logic [3:0] COIL_OFF = 4'hF;

	// full-step pattern, one coil pulled low
	function automatic logic [3:0] coil_pat(input logic [1:0] phase, input logic rev);
		logic [3:0] p;
		case (phase)
			2'd0: p = 4'd14;
			2'd1: p = 4'd13;
			2'd2: p = 4'd11;
			default: p = 4'd7;
		endcase
		return rev ? {p[0], p[1], p[2], p[3]} : p;
	endfunction

endpackage
`default_nettype wire

[src/serial_command_decoder_fan_control_unit.sv]
// Serial command decoder for fan duty, stepper bursts, relay and sensor flags.
// Input channel in_valid/in_ready carries one received byte or an acknowledge
// (opcode) per beat. Output channel out_valid/out_ready carries result beats.
// A byte passes the setup sequence (three "OK" replies, then "192") before
// command letters S, D, X, Y and their argument byte take effect.
// Each input beat gives one result beat, except a D argument that moves the
// stepper: one beat per step (6 to 36, at most MAX_STEPS); last marks the end.
// After acceptance the controller enters its run state and registers the first
// result once the output slot is free; step beats follow one a cycle from the
// shared phase counter while the receiver takes them; the controller handles
// one item at a time and in_ready is low while its beats are being produced.
// The output register holds a finished beat while the receiver stalls; the
// next item can be accepted as soon as the last beat is in that register.
// A stalled receiver holds the burst back one beat at a time.
// Reset clears setup progress, flags, phase and pending command; speed is 1.
// depends on scdfc_pkg, scdfc_ctrl, scdfc_dp
`default_nettype none
module serial_command_decoder_fan_control_unit #(
	parameter int MAX_STEPS = 36
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire scdfc_pkg::in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output scdfc_pkg::out_t      out_data
);
	import scdfc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	scdfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scdfc_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

[src/scdfc_ctrl.sv]
// controller: accepts one beat, then drives the result beats out
// depends on scdfc_pkg
`default_nettype none
module scdfc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire scdfc_pkg::dp_sts_t sts,
	output scdfc_pkg::dp_cmd_t     cmd
);
	import scdfc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.decode = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.decode = 1'b1;
					state_d    = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					if (sts.final_beat) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[src/scdfc_dp.sv]
// datapath: setup/command decode state, step burst counter, output register
// depends on scdfc_pkg and the assertion macro header
`default_nettype none
`include "serial_command_decoder_fan_control_unit_defines.svh"
module scdfc_dp #(
	parameter int MAX_STEPS = 36
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire scdfc_pkg::in_t     in_data,
	input  wire scdfc_pkg::dp_cmd_t cmd,
	output scdfc_pkg::dp_sts_t      sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output scdfc_pkg::out_t         out_data
);
	import scdfc_pkg::*;

	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam logic [6:0] MAX_CAP = 7'(MAX_STEPS);

	logic [2:0]    stage_q, stage_d;
	logic          ok_seen_q, ok_seen_d;
	logic [1:0]    prefix_q, prefix_d;
	cmd_t          pend_q, pend_d;
	logic [2:0]    speed_q, speed_d;
	logic          sensor_q, sensor_d;
	logic          auto_q, auto_d;
	logic          relay_q, relay_d;
	logic          load_q, load_d;
	logic [9:0]    duty_q, duty_d;
	logic          rev_q, rev_d;
	logic [6:0]    raw_steps;
	logic [CW-1:0] remain_q, remain_d;
	logic [1:0]    phase_q;
	logic          out_valid_q;
	out_t          out_q, beat;

	// decode of one accepted beat
	always_comb begin
		stage_d   = stage_q;
		ok_seen_d = ok_seen_q;
		prefix_d  = prefix_q;
		pend_d    = pend_q;
		speed_d   = speed_q;
		sensor_d  = sensor_q;
		auto_d    = auto_q;
		relay_d   = relay_q;
		load_d    = 1'b0;
		duty_d    = DUTY_OFF;
		rev_d     = 1'b0;
		raw_steps = 7'd0;
		if (in_data.opcode == OP_ACK) begin
			sensor_d = 1'b0;
		end else if (stage_q < STAGE_PREFIX) begin
			if (!ok_seen_q) begin
				if (in_data.rx_byte == CH_O) ok_seen_d = 1'b1;
			end else begin
				ok_seen_d = 1'b0;
				if (in_data.rx_byte == CH_K) stage_d = stage_q + 3'd1;
			end
		end else if (stage_q == STAGE_PREFIX) begin
			if (prefix_q == 2'd0) begin
				if (in_data.rx_byte == CH_1) prefix_d = 2'd1;
			end else if (in_data.rx_byte == CH_9 && prefix_q == 2'd1) begin
				prefix_d = 2'd2;
			end else if (in_data.rx_byte == CH_2 && prefix_q == 2'd2) begin
				prefix_d = 2'd0;
				stage_d  = STAGE_RUN;
			end else begin
				prefix_d = 2'd0;
			end
		end else if (stage_q == STAGE_RUN) begin
			pend_d = CMD_NONE;
			case (pend_q)
				CMD_NONE: begin
					if (in_data.rx_byte == CH_S) pend_d = CMD_S;
					else if (in_data.rx_byte == CH_D) pend_d = CMD_D;
					else if (in_data.rx_byte == CH_X) pend_d = CMD_X;
					else if (in_data.rx_byte == CH_Y) pend_d = CMD_Y;
				end
				CMD_S: begin
					load_d = 1'b1;
					case (in_data.rx_byte)
						CH_0: begin speed_d = 3'd1; duty_d = DUTY_FULL; end
						CH_1: begin speed_d = 3'd1; duty_d = DUTY_HIGH; end
						CH_2: begin speed_d = 3'd2; duty_d = DUTY_MID; end
						CH_3: begin speed_d = 3'd3; duty_d = DUTY_LOW; end
						CH_4: begin speed_d = 3'd4; duty_d = DUTY_OFF; end
						default: load_d = 1'b0;
					endcase
				end
				CMD_D: begin
					case (in_data.rx_byte)
						CH_1: raw_steps = 7'd12;
						CH_2: raw_steps = 7'd24;
						CH_3: raw_steps = 7'd36;
						CH_4: begin raw_steps = 7'd12; rev_d = 1'b1; end
						CH_5: begin raw_steps = 7'd24; rev_d = 1'b1; end
						CH_6: begin raw_steps = 7'd36; rev_d = 1'b1; end
						CH_7: raw_steps = 7'd6;
						CH_8: begin raw_steps = 7'd6; rev_d = 1'b1; end
						default: raw_steps = 7'd0;
					endcase
				end
				CMD_X: begin
					if (in_data.rx_byte == CH_3) begin
						sensor_d = 1'b1;
					end else if (in_data.rx_byte == CH_4) begin
						sensor_d = 1'b1;
						auto_d   = 1'b1;
					end else if (in_data.rx_byte == CH_2) begin
						sensor_d = 1'b1;
						auto_d   = 1'b0;
					end
				end
				CMD_Y: begin
					if (in_data.rx_byte == CH_0) relay_d = 1'b0;
					else if (in_data.rx_byte == CH_1) relay_d = 1'b1;
				end
				default: pend_d = CMD_NONE;
			endcase
		end
		remain_d = (raw_steps > MAX_CAP) ? CW'(MAX_STEPS) : CW'(raw_steps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= 3'd0;
			ok_seen_q <= 1'b0;
			prefix_q  <= 2'd0;
			pend_q    <= CMD_NONE;
			speed_q   <= 3'd1;
			sensor_q  <= 1'b0;
			auto_q    <= 1'b0;
			relay_q   <= 1'b0;
			remain_q  <= '0;
			phase_q   <= 2'd0;
		end else if (cmd.decode) begin
			stage_q   <= stage_d;
			ok_seen_q <= ok_seen_d;
			prefix_q  <= prefix_d;
			pend_q    <= pend_d;
			speed_q   <= speed_d;
			sensor_q  <= sensor_d;
			auto_q    <= auto_d;
			relay_q   <= relay_d;
			remain_q  <= remain_d;
		end else if (cmd.emit && remain_q != '0) begin
			remain_q <= remain_q - CW'(1);
			phase_q  <= phase_q + 2'd1;
		end
	end

	// per-beat payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			load_q <= load_d;
			duty_q <= duty_d;
			rev_q  <= rev_d;
		end
	end

	// result beat: single status beat when no steps, otherwise one step
	always_comb begin
		beat.speed_level    = speed_q;
		beat.relay_level    = relay_q;
		beat.sensor_request = sensor_q;
		beat.auto_mode      = auto_q;
		beat.setup_stage    = stage_q;
		if (remain_q == '0) begin
			beat.duty_load    = load_q;
			beat.duty_value   = duty_q;
			beat.coil_valid   = 1'b0;
			beat.coil_pattern = COIL_OFF;
			beat.last         = 1'b1;
		end else begin
			beat.duty_load    = 1'b0;
			beat.duty_value   = DUTY_OFF;
			beat.coil_valid   = 1'b1;
			beat.coil_pattern = coil_pat(phase_q, rev_q);
			beat.last         = (remain_q == CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_q <= beat;
	end

	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.final_beat = (remain_q <= CW'(1));
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	`SCDFC_ASSERT_SAME(a_emit_slot, cmd.emit, sts.slot_free, "beat emitted into a full slot")
	`SCDFC_ASSERT_SAME(a_stage_range, 1'b1, stage_q <= STAGE_RUN, "setup stage out of range")
	`SCDFC_ASSERT_NEXT(a_step_count, cmd.emit && remain_q != '0,
		remain_q == $past(remain_q) - CW'(1), "step count did not decrement")
	`SCDFC_ASSERT_NEXT(a_phase_step, cmd.emit && remain_q != '0,
		phase_q == $past(phase_q) + 2'd1, "phase did not advance on a step")

endmodule
`default_nettype wire

[tb/scdfc_beat_checker.sv]
// watches both channels of the serial command decoder, predicts every result
// beat from the accepted input beats and compares them in order
// depends on scdfc_pkg
`timescale 1ns / 1ps
module scdfc_beat_checker #(
	parameter int STEP_LIMIT = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  scdfc_pkg::in_t   in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  scdfc_pkg::out_t  out_data,
	output int               mismatches,
	output int               outstanding,
	output int               beats_in,
	output int               beats_out,
	output int               steps_out
);
	import scdfc_pkg::*;

	// predicted decoder state
	logic [2:0] stage_q;
	logic       ok_seen;
	logic [1:0] prefix_q;
	cmd_t       pending;
	logic [1:0] phase_q;
	logic [2:0] speed_q;
	logic       sensor_q;
	logic       auto_q;
	logic       relay_q;

	out_t expected_beats[$];

	function automatic logic [3:0] coil_drive(input logic [1:0] phase, input logic reverse);
		case ({reverse, phase})
			3'b000: return 4'd14;
			3'b001: return 4'd13;
			3'b010: return 4'd11;
			3'b011: return 4'd7;
			3'b100: return 4'd7;
			3'b101: return 4'd11;
			3'b110: return 4'd13;
			default: return 4'd14;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result beat %0d: %s got %0h want %0h", beats_out, what, got, want);
		mismatches++;
	endtask

	task automatic decode_beat(input in_t beat);
		logic       load;
		logic [9:0] duty;
		int         steps;
		logic       reverse;
		logic [7:0] b;
		out_t       r;
		load = 1'b0;
		duty = DUTY_OFF;
		steps = 0;
		reverse = 1'b0;
		b = beat.rx_byte;
		if (beat.opcode == OP_ACK) begin
			sensor_q = 1'b0;
		end else if (stage_q <= 3'd2) begin
			// waiting for the three ok replies
			if (!ok_seen) begin
				ok_seen = (b == CH_O);
			end else begin
				ok_seen = 1'b0;
				if (b == CH_K)
					stage_q = stage_q + 3'd1;
			end
		end else if (stage_q == STAGE_PREFIX) begin
			if (prefix_q == 2'd0) begin
				if (b == CH_1)
					prefix_q = 2'd1;
			end else if (b == CH_9 && prefix_q == 2'd1) begin
				prefix_q = 2'd2;
			end else if (b == CH_2 && prefix_q == 2'd2) begin
				prefix_q = 2'd0;
				stage_q = STAGE_RUN;
			end else begin
				prefix_q = 2'd0;
			end
		end else if (stage_q == STAGE_RUN) begin
			case (pending)
				CMD_NONE: begin
					case (b)
						CH_S: pending = CMD_S;
						CH_D: pending = CMD_D;
						CH_X: pending = CMD_X;
						CH_Y: pending = CMD_Y;
						default: ;
					endcase
				end
				CMD_S: begin
					case (b)
						CH_0: begin speed_q = 3'd1; duty = DUTY_FULL; load = 1'b1; end
						CH_1: begin speed_q = 3'd1; duty = DUTY_HIGH; load = 1'b1; end
						CH_2: begin speed_q = 3'd2; duty = DUTY_MID;  load = 1'b1; end
						CH_3: begin speed_q = 3'd3; duty = DUTY_LOW;  load = 1'b1; end
						CH_4: begin speed_q = 3'd4; duty = DUTY_OFF;  load = 1'b1; end
						default: ;
					endcase
					pending = CMD_NONE;
				end
				CMD_D: begin
					case (b)
						CH_1: steps = 12;
						CH_2: steps = 24;
						CH_3: steps = 36;
						CH_4: begin steps = 12; reverse = 1'b1; end
						CH_5: begin steps = 24; reverse = 1'b1; end
						CH_6: begin steps = 36; reverse = 1'b1; end
						CH_7: steps = 6;
						CH_8: begin steps = 6; reverse = 1'b1; end
						default: ;
					endcase
					if (steps > STEP_LIMIT)
						steps = STEP_LIMIT;
					pending = CMD_NONE;
				end
				CMD_X: begin
					if (b == CH_3) begin
						sensor_q = 1'b1;
					end else if (b == CH_4) begin
						sensor_q = 1'b1;
						auto_q = 1'b1;
					end else if (b == CH_2) begin
						sensor_q = 1'b1;
						auto_q = 1'b0;
					end
					pending = CMD_NONE;
				end
				CMD_Y: begin
					if (b == CH_0)
						relay_q = 1'b0;
					else if (b == CH_1)
						relay_q = 1'b1;
					pending = CMD_NONE;
				end
				default: pending = CMD_NONE;
			endcase
		end

		// status fields show the state after the beat
		r.duty_load = load;
		r.duty_value = duty;
		r.speed_level = speed_q;
		r.coil_valid = 1'b0;
		r.coil_pattern = COIL_OFF;
		r.relay_level = relay_q;
		r.sensor_request = sensor_q;
		r.auto_mode = auto_q;
		r.setup_stage = stage_q;
		r.last = 1'b1;
		if (steps == 0) begin
			expected_beats.push_back(r);
		end else begin
			for (int k = 0; k < steps; k++) begin
				r.coil_valid = 1'b1;
				r.coil_pattern = coil_drive(phase_q, reverse);
				r.last = (k == steps - 1);
				phase_q = phase_q + 2'd1;
				expected_beats.push_back(r);
			end
		end
	endtask

	task automatic compare_beat(input out_t got, input out_t want);
		if (got.duty_load !== want.duty_load)
			report_mismatch("duty_load", got.duty_load, want.duty_load);
		if (got.duty_value !== want.duty_value)
			report_mismatch("duty_value", got.duty_value, want.duty_value);
		if (got.speed_level !== want.speed_level)
			report_mismatch("speed_level", got.speed_level, want.speed_level);
		if (got.coil_valid !== want.coil_valid)
			report_mismatch("coil_valid", got.coil_valid, want.coil_valid);
		if (got.coil_pattern !== want.coil_pattern)
			report_mismatch("coil_pattern", got.coil_pattern, want.coil_pattern);
		if (got.relay_level !== want.relay_level)
			report_mismatch("relay_level", got.relay_level, want.relay_level);
		if (got.sensor_request !== want.sensor_request)
			report_mismatch("sensor_request", got.sensor_request, want.sensor_request);
		if (got.auto_mode !== want.auto_mode)
			report_mismatch("auto_mode", got.auto_mode, want.auto_mode);
		if (got.setup_stage !== want.setup_stage)
			report_mismatch("setup_stage", got.setup_stage, want.setup_stage);
		if (got.last !== want.last)
			report_mismatch("last", got.last, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			stage_q = 3'd0;
			ok_seen = 1'b0;
			prefix_q = 2'd0;
			pending = CMD_NONE;
			phase_q = 2'd0;
			speed_q = 3'd1;
			sensor_q = 1'b0;
			auto_q = 1'b0;
			relay_q = 1'b0;
			expected_beats.delete();
			mismatches = 0;
			beats_in = 0;
			beats_out = 0;
			steps_out = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_beat(in_data);
				beats_in++;
			end
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("beat with nothing outstanding", out_data, 0);
				end else begin
					want = expected_beats.pop_front();
					compare_beat(out_data, want);
				end
				if (out_data.coil_valid)
					steps_out++;
				beats_out++;
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

[tb/serial_command_decoder_fan_control_unit_test.sv]
// stimulus and verdict for the serial command decoder: setup sequence, then
// random command traffic with idling on both sides; checking is in scdfc_beat_checker
// depends on scdfc_pkg, scdfc_beat_checker and the decoder rtl
`timescale 1ns / 1ps
module serial_command_decoder_fan_control_unit_test;
	import scdfc_pkg::*;

	localparam int STEP_LIMIT   = 36;
	localparam int RANDOM_ITEMS = 420;
	localparam int LONG_HOLD    = 300;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// receiver and input gap controls set by the stimulus
	logic hold_go;
	logic calm;
	bit   gaps_on;

	int mismatches;
	int outstanding;
	int beats_in;
	int beats_out;
	int steps_out;

	serial_command_decoder_fan_control_unit #(
		.MAX_STEPS(STEP_LIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	scdfc_beat_checker #(
		.STEP_LIMIT(STEP_LIMIT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.beats_in    (beats_in),
		.beats_out   (beats_out),
		.steps_out   (steps_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic in_t byte_beat(input logic [7:0] b);
		in_t r;
		r.opcode = OP_BYTE;
		r.rx_byte = b;
		return r;
	endfunction

	function automatic in_t ack_beat(input logic [7:0] b);
		in_t r;
		r.opcode = OP_ACK;
		r.rx_byte = b;
		return r;
	endfunction

	// valid stays up across back to back beats
	task automatic send_beat(input in_t beat);
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(byte_beat(b));
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic pause_maybe();
		if (!calm && gaps_on && $urandom_range(0, 2) == 0)
			idle_cycles($urandom_range(1, 14));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_command();
		logic [7:0] letter;
		logic [7:0] arg;
		case ($urandom_range(0, 3))
			0: letter = CH_S;
			1: letter = CH_D;
			2: letter = CH_X;
			default: letter = CH_Y;
		endcase
		if ($urandom_range(0, 9) == 0)
			arg = 8'($urandom);
		else
			arg = CH_0 + 8'($urandom_range(0, 9));
		send_byte(letter);
		pause_maybe();
		send_byte(arg);
		pause_maybe();
	endtask

	// receiver: random stall bursts, quiet stretches, one long hold-off
	initial begin : receiver
		int  quiet;
		bit  held;
		quiet = 0;
		held = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_go && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (calm || quiet > 0) begin
				out_ready <= 1'b1;
				if (quiet > 0)
					quiet--;
				@(posedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 40) == 0)
					quiet = $urandom_range(30, 120);
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int  items_sent;
		int  roll;
		bit  hold_asked;
		bit  drain_done;
		items_sent = 0;
		hold_asked = 0;
		drain_done = 0;
		gaps_on = 1;
		in_valid <= 1'b0;
		in_data <= byte_beat(8'h00);
		hold_go <= 1'b0;
		calm <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// setup sequence with its corner cases
		send_byte(8'h00);
		send_byte(CH_O);
		send_byte(CH_O);
		send_byte(CH_K);
		send_byte(CH_O);
		send_byte(CH_K);
		send_beat(ack_beat(8'hFF));
		send_byte(CH_O);
		send_byte(8'hFF);
		idle_cycles(5);
		send_byte(CH_O);
		send_byte(CH_K);
		send_byte(CH_O);
		send_byte(CH_K);
		// repeated prefix start drops progress
		send_byte(CH_1);
		send_byte(CH_1);
		send_byte(CH_1);
		send_byte(CH_9);
		send_byte(CH_2);

		// one of each command, full-length bursts both ways
		send_byte(CH_S);
		send_byte(CH_4);
		send_byte(CH_S);
		send_byte(CH_0);
		send_byte(CH_D);
		send_byte(CH_3);
		send_byte(CH_D);
		send_byte(CH_6);
		send_byte(CH_X);
		send_byte(CH_4);
		send_beat(ack_beat(8'h00));
		send_byte(CH_Y);
		send_byte(CH_1);
		send_byte(8'hFF);
		send_byte(CH_S);
		send_byte(CH_9);
		wait_drained();

		while (items_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				send_command();
				items_sent += 2;
			end else if (roll < 87) begin
				send_beat(ack_beat(8'($urandom)));
				pause_maybe();
				items_sent++;
			end else begin
				// noise may start a command and swallow the next letter
				send_byte(8'($urandom));
				pause_maybe();
				items_sent++;
			end
			if ($urandom_range(0, 24) == 0)
				gaps_on = !gaps_on;
			if (!hold_asked && items_sent >= 100) begin
				hold_asked = 1;
				hold_go <= 1'b1;
			end
			if (!drain_done && items_sent >= 220) begin
				drain_done = 1;
				wait_drained();
			end
			if (items_sent >= 360)
				calm <= 1'b1;
		end

		wait_drained();
		repeat (16) @(posedge clk);
		$display("covered setup and %0d random items: %0d input beats, %0d result beats",
			items_sent, beats_in, beats_out);
		$display("stepper step beats checked: %0d, long receiver hold and full drain included",
			steps_out);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[serial_command_decoder_fan_control_unit.f]
+incdir+src
src/scdfc_pkg.sv
src/scdfc_ctrl.sv
src/scdfc_dp.sv
src/serial_command_decoder_fan_control_unit.sv
tb/scdfc_beat_checker.sv
tb/serial_command_decoder_fan_control_unit_test.sv
